// ===== src/kwtl_pkg.sv =====
package kwtl_pkg;

  // Token kind codes
  typedef logic [4:0] kind_t;

  localparam kind_t KIND_NUMBER  = 5'd0;
  localparam kind_t KIND_IDENT   = 5'd1;
  localparam kind_t KIND_LET     = 5'd2;
  localparam kind_t KIND_FN      = 5'd3;
  localparam kind_t KIND_RETURN  = 5'd4;
  localparam kind_t KIND_IF      = 5'd5;
  localparam kind_t KIND_ELSE    = 5'd6;
  localparam kind_t KIND_WHILE   = 5'd7;
  localparam kind_t KIND_PLUS    = 5'd8;
  localparam kind_t KIND_MINUS   = 5'd9;
  localparam kind_t KIND_STAR    = 5'd10;
  localparam kind_t KIND_SLASH   = 5'd11;
  localparam kind_t KIND_ASSIGN  = 5'd12;
  localparam kind_t KIND_LPAREN  = 5'd13;
  localparam kind_t KIND_RPAREN  = 5'd14;
  localparam kind_t KIND_LBRACE  = 5'd15;
  localparam kind_t KIND_RBRACE  = 5'd16;
  localparam kind_t KIND_COMMA   = 5'd17;
  localparam kind_t KIND_SEMI    = 5'd18;
  localparam kind_t KIND_INVALID = 5'd19;
  localparam kind_t KIND_END     = 5'd20;

  // Scanner mode
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2
  } mode_t;

  // One token as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
  } token_t;

  // All tokens caused by one byte, packed to the low slots
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } bundle_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

endpackage

// ===== src/kwtl_front.sv =====
module kwtl_front
  import kwtl_pkg::*;
#(
  parameter int POSITION_BITS   = 16,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_source,
  input  logic       q_ready,
  output logic       q_push,
  output bundle_t    q_data
);

  localparam int KIDX_W = $clog2(KEYWORD_MAX_LEN);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // low 16 bits of a position, zero-extended when positions are narrower
  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+15:0] e;
    e = {16'd0, p};
    return e[15:0];
  endfunction

  // keyword match on the first six buffered bytes
  function automatic kind_t kw_kind(input logic [5:0][7:0] b, input logic [15:0] len);
    kind_t k;
    k = KIND_IDENT;
    if (len == 16'd3 && {b[0], b[1], b[2]} == "let") k = KIND_LET;
    if (len == 16'd2 && {b[0], b[1]} == "fn") k = KIND_FN;
    if (len == 16'd6 && {b[0], b[1], b[2], b[3], b[4], b[5]} == "return") k = KIND_RETURN;
    if (len == 16'd2 && {b[0], b[1]} == "if") k = KIND_IF;
    if (len == 16'd4 && {b[0], b[1], b[2], b[3]} == "else") k = KIND_ELSE;
    if (len == 16'd5 && {b[0], b[1], b[2], b[3], b[4]} == "while") k = KIND_WHILE;
    return k;
  endfunction

  // single-character operators, anything else is invalid
  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "=":     k = KIND_ASSIGN;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  mode_t                     mode_r, mode_nxt;
  logic [POSITION_BITS-1:0]  pos_r, pos_nxt, pos_inc;
  logic [POSITION_BITS-1:0]  start_r, start_nxt;
  logic [15:0]               len_r, len_nxt;
  logic                      ended_r, ended_nxt;
  logic [7:0]                kbuf_r [KEYWORD_MAX_LEN];

  logic                      accept;
  logic [7:0]                c;
  logic                      is_dig, is_alpha, is_sp, is_id, cont;
  logic                      kw_we;
  logic [KIDX_W-1:0]         kw_idx;
  logic [5:0][7:0]           view_cur, view_nxt;
  logic                      va, vb, vc;
  token_t                    tok_a, tok_b, tok_c;
  mode_t                     close_mode;

  assign accept   = in_valid && in_ready;
  assign in_ready = q_ready;
  assign c        = in_char_byte;

  // character classes
  assign is_dig   = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_sp    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_id    = is_alpha || is_dig || (c == CHAR_UNDER);
  assign cont     = ((mode_r == MODE_NUMBER) && is_dig) || ((mode_r == MODE_IDENT) && is_id);

  // keyword buffer as it is now and as it will be after this byte
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      view_cur[i] = kbuf_r[i];
      view_nxt[i] = (kw_we && (kw_idx == KIDX_W'(i))) ? c : kbuf_r[i];
    end
  end

  // classify the byte, update scan state, collect tokens
  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    ended_nxt  = ended_r;
    pos_nxt    = pos_r;
    pos_inc    = pos_r;
    kw_we      = 1'b0;
    kw_idx     = len_r[KIDX_W-1:0];
    va         = 1'b0;
    vb         = 1'b0;
    vc         = 1'b0;
    tok_a      = '0;
    tok_b      = '0;
    tok_c      = '0;
    close_mode = MODE_IDLE;

    if (!ended_r) begin
      if (cont) begin
        kw_we   = (len_r < 16'(KEYWORD_MAX_LEN));
        len_nxt = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
      end else begin
        // close the pending token first
        va          = (mode_r != MODE_IDLE);
        tok_a.kind  = (mode_r == MODE_NUMBER) ? KIND_NUMBER : kw_kind(view_cur, len_r);
        tok_a.start = pos16(start_r);
        tok_a.len   = len_r;
        mode_nxt    = MODE_IDLE;
        if (c == CHAR_NUL) begin
          vb          = 1'b1;
          tok_b.kind  = KIND_END;
          tok_b.start = pos16(pos_r);
          ended_nxt   = 1'b1;
        end else if (is_sp) begin
          mode_nxt = MODE_IDLE;
        end else if (is_dig || is_alpha || (c == CHAR_UNDER)) begin
          mode_nxt  = is_dig ? MODE_NUMBER : MODE_IDENT;
          start_nxt = pos_r;
          len_nxt   = 16'd1;
          kw_we     = 1'b1;
          kw_idx    = '0;
        end else begin
          vb          = 1'b1;
          tok_b.kind  = op_kind(c);
          tok_b.start = pos16(pos_r);
          tok_b.len   = 16'd1;
          tok_b.bad   = (op_kind(c) == KIND_INVALID) ? c : 8'd0;
        end
      end
      pos_inc = (!ended_nxt && (pos_r != POS_MAX)) ? pos_r + 1'b1 : pos_r;
      pos_nxt = pos_inc;

      // marked last byte: close whatever is open, then the end token;
      // an operator or invalid token in slot b leaves nothing open
      if (in_end_of_source && !ended_nxt) begin
        close_mode = mode_nxt;
        if (close_mode != MODE_IDLE) begin
          vb          = 1'b1;
          tok_b.kind  = (close_mode == MODE_NUMBER) ? KIND_NUMBER : kw_kind(view_nxt, len_nxt);
          tok_b.start = pos16(start_nxt);
          tok_b.len   = len_nxt;
          tok_b.bad   = 8'd0;
        end
        vc          = 1'b1;
        tok_c.kind  = KIND_END;
        tok_c.start = pos16(pos_inc);
      end
    end

    // a new source starts after the marked last byte
    if (in_end_of_source) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = 16'd0;
      ended_nxt = 1'b0;
    end
  end

  // pack valid tokens to the low slots
  always_comb begin
    q_data.cnt    = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    q_data.tok[0] = va ? tok_a : (vb ? tok_b : tok_c);
    q_data.tok[1] = va ? (vb ? tok_b : tok_c) : tok_c;
    q_data.tok[2] = tok_c;
  end

  assign q_push = accept && (q_data.cnt != 2'd0);

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= 16'd0;
      ended_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      ended_r <= ended_nxt;
    end
  end

  // keyword buffer, no reset
  always_ff @(posedge clk) begin
    if (accept && kw_we) begin
      kbuf_r[kw_idx] <= c;
    end
  end

endmodule

// ===== src/kwtl_queue.sv =====
module kwtl_queue
  import kwtl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    push_ready,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !push_ready))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("queue popped while empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

// ===== src/kwtl_back.sv =====
module kwtl_back
  import kwtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_pos,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_bad_char,
  output logic        out_last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  token_t     out_tok_r;
  logic       out_last_r;
  token_t     sel_tok;
  logic       load, sel_last;

  // pick the next token of the head bundle
  always_comb begin
    unique case (idx_r)
      2'd0:    sel_tok = head.tok[0];
      2'd1:    sel_tok = head.tok[1];
      default: sel_tok = head.tok[2];
    endcase
  end

  assign sel_last = (idx_r == head.cnt - 2'd1);
  assign load     = head_valid && (!out_valid_r || out_ready);
  assign pop      = load && sel_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = sel_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= sel_tok;
      out_last_r <= sel_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_tok_r.kind;
  assign out_start_pos    = out_tok_r.start;
  assign out_token_length = out_tok_r.len;
  assign out_bad_char     = out_tok_r.bad;
  assign out_last_of_run  = out_last_r;

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < head.cnt))
    else $error("token index past end of bundle");

endmodule

// ===== src/keyword_token_lexer.sv =====
// Byte-serial lexer: source text in, one token per output item.
// Input channel (in_valid/in_ready): one source byte per item plus a flag
// marking the final byte. A zero byte also ends the source; bytes after it
// are dropped until the marked final byte, after which positions restart.
// Output channel (out_valid/out_ready): token kind, start position, length
// (saturating), offending byte for invalid tokens, and a flag on the last
// token caused by one input byte.
// The first token caused by a byte passes through the queue write and then
// the output register before it is presented.
// Throughput: one byte per cycle while each byte causes at most one token
// and out_ready stays high. A byte that closes a token and makes another,
// or ends the source, causes up to three tokens, presented in turn; a
// four-entry queue between the classifier and the output stage absorbs such
// bursts. When the receiver stalls the queue fills and in_ready drops once
// it holds four bytes' worth of tokens.
// Reset (rst_n low, synchronous) empties the queue, drops any pending token
// and restarts positions at zero.
module keyword_token_lexer
  import kwtl_pkg::*;
#(
  parameter int POSITION_BITS   = 16,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_pos,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_bad_char,
  output logic        out_last_of_run
);

  logic    q_push, q_ready, q_pop, q_head_valid;
  bundle_t q_data, q_head;

  kwtl_front #(
    .POSITION_BITS   (POSITION_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  kwtl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  kwtl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_pos    (out_start_pos),
    .out_token_length (out_token_length),
    .out_bad_char     (out_bad_char),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== dv/tb_keyword_token_lexer.sv =====
`timescale 1ns / 100ps

module tb_keyword_token_lexer;
  import kwtl_pkg::*;

  localparam int POS_SAT = 65535;
  localparam int LEN_SAT = 65535;
  localparam int KW_MAX = 6;
  localparam int DRAIN_CYCLES = 16;

  // One token the block is expected to produce
  typedef struct {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } token_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_end_of_source = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_start_pos;
  logic [15:0] out_token_length;
  logic [7:0]  out_bad_char;
  logic        out_last_of_run;

  keyword_token_lexer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_pos    (out_start_pos),
    .out_token_length (out_token_length),
    .out_bad_char     (out_bad_char),
    .out_last_of_run  (out_last_of_run)
  );

  always #2 clk = ~clk;

  string kw_words[6] = '{"let", "fn", "return", "if", "else", "while"};
  string op_chars = "+-*/=(){},;";

  token_exp_t  token_q[$];
  token_exp_t  step_toks[$];
  logic [7:0]  src_q[$];

  // Lexer shadow state
  mode_t       lex_mode;
  int unsigned lex_pos;
  int unsigned lex_start;
  int unsigned lex_len;
  logic [7:0]  lex_buf[KW_MAX];
  bit          lex_done;

  int          tx_idle = 0;
  int          rx_idle = 0;
  int unsigned live_items = 0;
  int unsigned err_count = 0;
  int          kw_turn = 0;
  int          op_turn = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  // ---------------- token prediction ----------------

  function automatic bit char_is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit char_is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void restart_source();
    lex_mode = MODE_IDLE;
    lex_pos = 0;
    lex_start = 0;
    lex_len = 0;
    lex_done = 1'b0;
  endfunction

  function automatic void emit_tok(kind_t k, int unsigned s, int unsigned l, logic [7:0] b);
    token_exp_t t;
    t.kind = k;
    t.start = s[15:0];
    t.len = l[15:0];
    t.bad = b;
    t.last = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  // keyword compare only looks at bytes written for the current token
  function automatic kind_t ident_class();
    bit hit;
    for (int k = 0; k < 6; k++) begin
      if (lex_len == kw_words[k].len()) begin
        hit = 1'b1;
        for (int i = 0; i < kw_words[k].len(); i++)
          if (lex_buf[i] != kw_words[k][i]) hit = 1'b0;
        if (hit) return kind_t'(int'(KIND_LET) + k);
      end
    end
    return KIND_IDENT;
  endfunction

  function automatic void close_tok();
    if (lex_mode == MODE_NUMBER)
      emit_tok(KIND_NUMBER, lex_start, lex_len, 8'h00);
    else if (lex_mode == MODE_IDENT)
      emit_tok(ident_class(), lex_start, lex_len, 8'h00);
    lex_mode = MODE_IDLE;
  endfunction

  function automatic void open_tok(mode_t m, logic [7:0] c);
    lex_mode = m;
    lex_start = lex_pos;
    lex_len = 1;
    lex_buf[0] = c;
  endfunction

  function automatic void grow_tok(logic [7:0] c);
    if (lex_len < KW_MAX) lex_buf[lex_len] = c;
    if (lex_len < LEN_SAT) lex_len++;
  endfunction

  // Expected tokens for one accepted byte
  function automatic void predict_tokens(logic [7:0] c, logic eos);
    int op_idx;
    step_toks.delete();
    // after end of source everything is dropped; a marked byte restarts
    if (lex_done) begin
      if (eos) restart_source();
      return;
    end
    live_items++;
    if (lex_mode == MODE_NUMBER && char_is_digit(c)) begin
      grow_tok(c);
    end else if (lex_mode == MODE_IDENT &&
                 (char_is_letter(c) || char_is_digit(c) || c == CHAR_UNDER)) begin
      grow_tok(c);
    end else begin
      close_tok();
      if (c == CHAR_NUL) begin
        emit_tok(KIND_END, lex_pos, 0, 8'h00);
        lex_done = 1'b1;
      end else if (char_is_blank(c)) begin
        // skipped
      end else if (char_is_digit(c)) begin
        open_tok(MODE_NUMBER, c);
      end else if (char_is_letter(c) || c == CHAR_UNDER) begin
        open_tok(MODE_IDENT, c);
      end else begin
        op_idx = -1;
        for (int k = 0; k < op_chars.len(); k++)
          if (c == op_chars[k]) op_idx = k;
        if (op_idx >= 0)
          emit_tok(kind_t'(int'(KIND_PLUS) + op_idx), lex_pos, 1, 8'h00);
        else
          emit_tok(KIND_INVALID, lex_pos, 1, c);
      end
    end
    if (!lex_done && lex_pos < POS_SAT) lex_pos++;
    // marked last byte closes the source
    if (eos) begin
      if (!lex_done) begin
        close_tok();
        emit_tok(KIND_END, lex_pos, 0, 8'h00);
      end
      restart_source();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    token_q = {token_q, step_toks};
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    token_exp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        report_mismatch("token with none expected, kind", out_token_kind, 0);
      end else begin
        want = token_q.pop_front();
        if (out_token_kind !== want.kind)
          report_mismatch("token_kind", out_token_kind, want.kind);
        if (out_start_pos !== want.start)
          report_mismatch("start_pos", out_start_pos, want.start);
        if (out_token_length !== want.len)
          report_mismatch("token_length", out_token_length, want.len);
        if (out_bad_char !== want.bad)
          report_mismatch("bad_char", out_bad_char, want.bad);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  // ---------------- stimulus ----------------

  task automatic send_byte(input logic [7:0] c, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_end_of_source <= eos;
    do @(posedge clk); while (!in_ready);
    predict_tokens(c, eos);
  endtask

  task automatic send_str(input string s, input logic mark);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], mark && (i == s.len() - 1));
  endtask

  // hold the sender until every expected token is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void src_add(logic [7:0] c);
    src_q = {src_q, c};
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CHAR_UNDER;
  endfunction

  function automatic void add_token();
    int r;
    int cut;
    logic [7:0] c;
    case ($urandom_range(4))
      0: repeat ($urandom_range(1, 5)) src_add(8'("0" + $urandom_range(9)));
      1: begin
        r = $urandom_range(52);
        src_add(r == 52 ? CHAR_UNDER :
                (r < 26 ? 8'("a" + r) : 8'("A" + r - 26)));
        repeat ($urandom_range(0, 8)) src_add(pick_word_char());
      end
      2: begin
        // keywords in turn, sometimes a near miss
        r = $urandom_range(5);
        cut = (r == 1) ? 1 : 0;
        for (int i = 0; i < kw_words[kw_turn].len() - cut; i++)
          src_add(kw_words[kw_turn][i]);
        if (r == 0) src_add(pick_word_char());
        kw_turn = (kw_turn + 1) % 6;
      end
      3: begin
        src_add(op_chars[op_turn]);
        op_turn = (op_turn + 1) % op_chars.len();
      end
      default: begin
        do c = 8'($urandom_range(1, 255));
        while (char_is_blank(c) || char_is_digit(c) || char_is_letter(c) ||
               c == CHAR_UNDER || c == "+" || c == "-" || c == "*" || c == "/" ||
               c == "=" || c == "(" || c == ")" || c == "{" || c == "}" ||
               c == "," || c == ";");
        src_add(c);
      end
    endcase
  endfunction

  function automatic void add_gap();
    int r;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(5);
      src_add(r == 5 ? 8'h20 : 8'(9 + r));
    end
  endfunction

  task automatic flush_src();
    for (int i = 0; i < src_q.size(); i++)
      send_byte(src_q[i], i == src_q.size() - 1);
  endtask

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // digit run into identifier, invalid high byte, keyword closed by operator,
  // every operator, zero byte with dropped bytes and a dropped marked byte
  task automatic test_token_basics();
    send_str("9x_ ", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("\tlet+-*/=(){},;", 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_byte("q", 1'b0);
    send_byte("w", 1'b1);
  endtask

  // marked last byte inside a token, zero byte that is also marked,
  // a lone marked invalid byte
  task automatic test_source_end();
    send_str("if", 1'b1);
    send_str("12", 1'b0);
    send_byte(CHAR_NUL, 1'b1);
    send_byte(8'h7F, 1'b1);
  endtask

  // mostly well-formed sources, some zero-terminated with trailing noise,
  // some pure noise
  task automatic test_random_sources(input int unsigned n_items);
    int unsigned base;
    int r;
    int n;
    base = live_items;
    while (live_items - base < n_items) begin
      r = $urandom_range(99);
      if (r < 12) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(15) == 0));
      end else begin
        src_q.delete();
        repeat ($urandom_range(1, 8)) begin
          add_token();
          add_gap();
        end
        if (r >= 75) begin
          src_add(CHAR_NUL);
          repeat ($urandom_range(0, 4)) src_add(8'($urandom_range(255)));
        end
        flush_src();
      end
    end
  endtask

  // identifier longer than the keyword buffer that starts with a keyword
  task automatic test_long_ident();
    send_str("return_value_7b", 1'b0);
    send_byte("+", 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  initial begin
    restart_source();
    do_reset();
    tx_idle = 37;
    rx_idle = 57;
    test_token_basics();
    test_source_end();
    test_random_sources(28);
    wait_drained();
    tx_idle = 57;
    rx_idle = 37;
    test_random_sources(28);
    wait_drained();
    tx_idle = 0;
    rx_idle = 0;
    test_random_sources(28);
    test_long_ident();
    wait_drained();
    if (token_q.size() != 0)
      report_mismatch("tokens never produced", token_q.size(), 0);
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== keyword_token_lexer.f =====
src/kwtl_pkg.sv
src/kwtl_front.sv
src/kwtl_queue.sv
src/kwtl_back.sv
src/keyword_token_lexer.sv
dv/tb_keyword_token_lexer.sv
